FILE: rtl/spq_pkg.sv
// spq_pkg: shared types for the stable priority queue.
// Holds the controller state type and the command word broadcast along the cell chain.
// No dependencies.
package spq_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} spq_state_t;

	// Broadcast to every cell each cycle.
	typedef struct packed {
		logic                     insert;
		logic                     rotate;
		logic signed [DATA_W-1:0] code;
		logic signed [DATA_W-1:0] prio;
	} spq_cmd_t;

endpackage

FILE: rtl/stable_priority_queue_unit.sv
// stable_priority_queue_unit: sorted-insert priority queue built as a chain of cells.
// Depends on spq_pkg and spq_cell.
//
// Usage
//   Input channel (in_valid / in_stall) carries one word per item: opcode 0 inserts
//   (entry_code, entry_priority), opcode 1 dumps the store. Output channel
//   (out_valid / out_stall) carries the dump results from a registered stage.
//   Entries are kept in ascending signed priority; equal priorities keep arrival
//   order because a new word only displaces strictly larger priorities.
// Timing
//   All cells compare and shift together on an insert, so inserts stream at one word
//   per cycle while no dump is in progress. An insert into a full store is dropped
//   and sets the sticky overflow flag; it yields no output.
//   A dump of n entries rotates the chain once per output word, reading cell 0;
//   an empty store yields a single word. After n rotations the chain is back in
//   its original order. in_stall is held high from the dump word until its last
//   result is loaded into the output register. While out_stall and out_valid are
//   both high, the output register holds and the rotation pauses.
// Reset
//   arst_n clears the entry count, the overflow flag, the controller state and
//   out_valid. Cell contents are left as they are; they are never read unwritten.
module stable_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic signed [DATA_W-1:0] entry_code,
	input  logic signed [DATA_W-1:0] entry_priority,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_code,
	output logic signed [DATA_W-1:0] out_priority,
	output logic                     is_last,
	output logic                     is_empty,
	output logic                     overflowed
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	spq_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic          ovf_q;

	logic in_acc, do_insert, dump_step, dump_last, store_empty, out_free;
	spq_cmd_t cmd;

	logic signed [DATA_W-1:0] cell_code [DEPTH];
	logic signed [DATA_W-1:0] cell_prio [DEPTH];
	logic                     cell_shift [DEPTH];

	assign in_acc      = in_valid && !in_stall;
	assign store_empty = (count_q == '0);
	assign out_free    = !out_valid || !out_stall;
	assign do_insert   = in_acc && (opcode == 1'b0) && (count_q != CW'(DEPTH));
	// Position of the word now at the head of the chain is idx_q.
	assign dump_last   = store_empty || ((CW'(idx_q) + CW'(1)) == count_q);

	// Controller: idle takes words, dump streams the chain out of cell 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b0;
		dump_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && opcode == 1'b1) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				in_stall  = 1'b1;
				dump_step = out_free;
				if (out_free && dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end
			if (in_acc && opcode == 1'b0 && count_q == CW'(DEPTH)) begin
				ovf_q <= 1'b1;
			end
			if (in_acc && opcode == 1'b1) begin
				idx_q <= '0;
			end else if (dump_step && !dump_last) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_comb begin
		cmd.insert = do_insert;
		cmd.rotate = dump_step && !store_empty;
		cmd.code   = entry_code;
		cmd.prio   = entry_priority;
	end

	// Cell chain: left neighbour feeds inserts, right neighbour feeds the rotation,
	// the cell holding the tail wraps round to cell 0.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     occ;
		logic                     lshift;
		logic signed [DATA_W-1:0] lcode, lprio, rcode, rprio;
		logic                     tail;

		assign occ  = CW'(i) < count_q;
		assign tail = (CW'(i) + CW'(1)) == count_q;

		if (i == 0) begin : g_head
			assign lshift = 1'b0;
			assign lcode  = '0;
			assign lprio  = '0;
		end else begin : g_body
			assign lshift = cell_shift[i-1];
			assign lcode  = cell_code[i-1];
			assign lprio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign rcode = cell_code[0];
			assign rprio = cell_prio[0];
		end else begin : g_mid
			assign rcode = tail ? cell_code[0] : cell_code[i+1];
			assign rprio = tail ? cell_prio[0] : cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (occ),
			.left_shift (lshift),
			.left_code  (lcode),
			.left_prio  (lprio),
			.right_code (rcode),
			.right_prio (rprio),
			.shift      (cell_shift[i]),
			.code       (cell_code[i]),
			.prio       (cell_prio[i])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (dump_step) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dump_step) begin
			out_code     <= store_empty ? '0 : cell_code[0];
			out_priority <= store_empty ? '0 : cell_prio[0];
			is_last      <= dump_last;
			is_empty     <= store_empty;
			overflowed   <= ovf_q;
		end
	end

endmodule

FILE: rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holding a single (code, priority) entry.
// Compares against the broadcast insert word and shifts or rotates with its neighbours.
// Depends on spq_pkg.
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  spq_cmd_t                 cmd,
	input  logic                     occupied,
	input  logic                     left_shift,
	input  logic signed [DATA_W-1:0] left_code,
	input  logic signed [DATA_W-1:0] left_prio,
	input  logic signed [DATA_W-1:0] right_code,
	input  logic signed [DATA_W-1:0] right_prio,
	output logic                     shift,
	output logic signed [DATA_W-1:0] code,
	output logic signed [DATA_W-1:0] prio
);

	logic signed [DATA_W-1:0] code_q;
	logic signed [DATA_W-1:0] prio_q;

	// Empty slots count as larger than anything, so a word no smaller than every entry lands at the tail.
	assign shift = !occupied || (prio_q > cmd.prio);

	always_ff @(posedge clk) begin
		if (cmd.insert && shift) begin
			if (left_shift) begin
				code_q <= left_code;
				prio_q <= left_prio;
			end else begin
				code_q <= cmd.code;
				prio_q <= cmd.prio;
			end
		end else if (cmd.rotate) begin
			code_q <= right_code;
			prio_q <= right_prio;
		end
	end

	assign code = code_q;
	assign prio = prio_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for stable_priority_queue_unit.
// It drives insert and dump words, keeps its own sorted copy of the store and checks
// every dump word. Depends on spq_pkg and the queue RTL.
module tb;
	import spq_pkg::*;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned TOTAL_WORDS  = 270;
	localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no handshake on either side
	localparam int unsigned DRAIN_CYCLES = 24;    // run-out after the last due dump word, catches stray words
	localparam int unsigned PHASE_WORDS  = 30;    // input words per pacing phase

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

	// One dump word as seen on the output side.
	typedef struct {
		logic signed [DATA_W-1:0] code;
		logic signed [DATA_W-1:0] prio;
		logic                     last;
		logic                     empty;
		logic                     ovf;
	} dump_word_t;

	// Mirror of the sorted store plus the dump words still owed by the block.
	class spq_scoreboard;
		logic signed [DATA_W-1:0] held_code[$];
		logic signed [DATA_W-1:0] held_prio[$];
		logic                     dropped_flag;
		dump_word_t               dump_due[$];
		int unsigned              mismatches;
		int unsigned              checked;

		function new();
			dropped_flag = 1'b0;
			mismatches   = 0;
			checked      = 0;
		endfunction

		// Prints one line per mismatch (capped so a dead block cannot flood the log).
		task report(string what);
			mismatches++;
			if (mismatches <= 40) begin
				$display("[%0t] mismatch: %s", $time, what);
			end
		endtask

		// Called for every accepted input word.
		function void note_word(logic op, logic signed [DATA_W-1:0] code,
				logic signed [DATA_W-1:0] prio);
			int         pos;
			dump_word_t w;
			if (op == OP_INSERT) begin
				// full store: word dropped, sticky flag raised
				if (held_prio.size() >= DEPTH) begin
					dropped_flag = 1'b1;
					return;
				end
				// go past every entry with priority <= new one, keeps arrival order on ties
				pos = 0;
				while (pos < held_prio.size() && held_prio[pos] <= prio) begin
					pos++;
				end
				held_code.insert(pos, code);
				held_prio.insert(pos, prio);
			end else if (held_prio.size() == 0) begin
				w.code  = '0;
				w.prio  = '0;
				w.last  = 1'b1;
				w.empty = 1'b1;
				w.ovf   = dropped_flag;
				dump_due.push_back(w);
			end else begin
				foreach (held_prio[k]) begin
					w.code  = held_code[k];
					w.prio  = held_prio[k];
					w.last  = (k == held_prio.size() - 1);
					w.empty = 1'b0;
					w.ovf   = dropped_flag;
					dump_due.push_back(w);
				end
			end
		endfunction

		task check_dump_word(dump_word_t got);
			dump_word_t want;
			if (dump_due.size() == 0) begin
				report($sformatf("unexpected word code %0d prio %0d", got.code, got.prio));
				return;
			end
			want = dump_due.pop_front();
			checked++;
			if (got.code !== want.code) begin
				report($sformatf("out_code %0d, want %0d", got.code, want.code));
			end
			if (got.prio !== want.prio) begin
				report($sformatf("out_priority %0d, want %0d", got.prio, want.prio));
			end
			if (got.last !== want.last) begin
				report($sformatf("is_last %b, want %b", got.last, want.last));
			end
			if (got.empty !== want.empty) begin
				report($sformatf("is_empty %b, want %b", got.empty, want.empty));
			end
			if (got.ovf !== want.ovf) begin
				report($sformatf("overflowed %b, want %b", got.ovf, want.ovf));
			end
		endtask
	endclass

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     opcode = OP_INSERT;
	logic signed [DATA_W-1:0] entry_code = '0;
	logic signed [DATA_W-1:0] entry_priority = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] out_code;
	logic signed [DATA_W-1:0] out_priority;
	logic                     is_last;
	logic                     is_empty;
	logic                     overflowed;

	spq_scoreboard spq = new();

	// pacing knobs, percent of cycles idle / stalled
	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned words_sent  = 0;
	int unsigned inserts_sent = 0;
	int unsigned dumps_sent  = 0;
	int unsigned idle_cycles = 0;

	stable_priority_queue_unit #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.entry_code     (entry_code),
		.entry_priority (entry_priority),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_code       (out_code),
		.out_priority   (out_priority),
		.is_last        (is_last),
		.is_empty       (is_empty),
		.overflowed     (overflowed)
	);

	always #10 clk = ~clk;

	// Pacing cycles through four phases as words go by: free running, sender
	// mostly idle, receiver mostly stalling, and both idling now and then.
	task automatic set_pacing();
		case ((words_sent / PHASE_WORDS) % 4)
			0: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_gap_pct   = 67;
				recv_stall_pct = 0;
			end
			2: begin
				send_gap_pct   = 0;
				recv_stall_pct = 67;
			end
			default: begin
				send_gap_pct   = 11;
				recv_stall_pct = 11;
			end
		endcase
	endtask

	// Entered and left at a falling edge. valid stays high between back-to-back
	// words, so it is never dropped and raised in one time step.
	task automatic send_word(logic op, logic signed [DATA_W-1:0] code,
			logic signed [DATA_W-1:0] prio);
		set_pacing();
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		opcode         <= op;
		entry_code     <= code;
		entry_priority <= prio;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		spq.note_word(op, code, prio);
		words_sent++;
		if (op == OP_INSERT) begin
			inserts_sent++;
		end else begin
			dumps_sent++;
		end
		@(negedge clk);
	endtask

	// Priority mix: a narrow band around zero gives plenty of ties, the ends of the
	// range test signed ordering, the rest is full range.
	function automatic logic signed [DATA_W-1:0] pick_prio();
		case ($urandom_range(4))
			0:       return MOST_NEG;
			1:       return MOST_POS;
			2, 3:    return DATA_W'($urandom_range(6)) - 32'sd3;
			default: return $urandom();
		endcase
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : result_check
		dump_word_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.code  = out_code;
			got.prio  = out_priority;
			got.last  = is_last;
			got.empty = is_empty;
			got.ovf   = overflowed;
			spq.check_dump_word(got);
		end
	end

	// Watchdog: a run of cycles with no handshake on either channel means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d words still due",
					idle_cycles, spq.dump_due.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty dump first, then the signed extremes and ties on both ends.
		send_word(OP_DUMP, MOST_POS, MOST_NEG);
		send_word(OP_INSERT, MOST_POS, MOST_POS);
		send_word(OP_INSERT, MOST_NEG, MOST_NEG);
		send_word(OP_INSERT, -32'sd1, 32'sd0);
		send_word(OP_INSERT, 32'sd0, 32'sd0);     // tie, must follow the earlier zero
		send_word(OP_INSERT, 32'sd1, -32'sd1);
		send_word(OP_DUMP, '0, '0);
		send_word(OP_INSERT, 32'sd2, MOST_POS);   // tie at the top end
		send_word(OP_INSERT, 32'sd3, MOST_NEG);   // tie at the bottom end
		send_word(OP_DUMP, '0, '0);

		// Random fill up to capacity, dumps mixed in so partial stores get read out.
		while (spq.held_prio.size() < DEPTH) begin
			if ($urandom_range(9) < 3) begin
				send_word(OP_DUMP, $urandom(), $urandom());
			end else begin
				send_word(OP_INSERT, $urandom(), pick_prio());
			end
		end

		// Directed: full store, then dropped inserts raise the sticky flag.
		send_word(OP_DUMP, '0, '0);
		send_word(OP_INSERT, 32'sh5555_aaaa, MOST_NEG);
		send_word(OP_DUMP, '0, '0);
		send_word(OP_INSERT, MOST_NEG, 32'sd0);
		send_word(OP_DUMP, '0, '0);

		// Random tail: store stays full, dumps check that nothing moves and the flag
		// stays set; the inserts exercise every field bit.
		while (words_sent < TOTAL_WORDS) begin
			if ($urandom_range(1) == 1) begin
				send_word(OP_DUMP, $urandom(), $urandom());
			end else begin
				send_word(OP_INSERT, $urandom(), $urandom());
			end
		end
		in_valid <= 1'b0;

		while (spq.dump_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words (%0d inserts, %0d dumps), checked %0d dump words",
			words_sent, inserts_sent, dumps_sent, spq.checked);
		$display("covered empty dump, signed extremes, equal-priority order, full store "
			, "and sticky overflow under sender gaps and receiver stalls");
		if (spq.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
